/* rtl/e8alu_pkg.sv */
`timescale 1ns / 1ps

package e8alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_DAA  = 5'd10,
    OP_CPL  = 5'd11,
    OP_SCF  = 5'd12,
    OP_CCF  = 5'd13,
    OP_RLC  = 5'd14,
    OP_RRC  = 5'd15,
    OP_RL   = 5'd16,
    OP_RR   = 5'd17,
    OP_SLA  = 5'd18,
    OP_SRA  = 5'd19,
    OP_SWAP = 5'd20,
    OP_SRL  = 5'd21,
    OP_BIT  = 5'd22,
    OP_RES  = 5'd23,
    OP_SET  = 5'd24,
    OP_RLCA = 5'd25,
    OP_RRCA = 5'd26,
    OP_RLA  = 5'd27,
    OP_RRA  = 5'd28
  } alu_op_t;

  // flag nibble layout
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

  // stage 1 to stage 2: operands plus adder results
  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
    logic [3:0] f;
    logic [2:0] idx;
    logic [8:0] sum;
    logic       h_add;
    logic [8:0] diff;
    logic       h_sub;
  } s1_t;

  // stage 2 to stage 3: result and flags except the zero test
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] z_val;
    logic       z_use;
    logic       z_fix;
    logic [2:0] nhc;
    logic       wb;
  } s2_t;

endpackage

/* rtl/e8alu_ifs.sv */
`timescale 1ns / 1ps

interface e8alu_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] mode;
  logic [7:0] operand_a;
  logic [7:0] operand_b;
  logic [3:0] flags_in;
  logic [2:0] bit_index;

  modport source (output valid, mode, operand_a, operand_b, flags_in, bit_index,
                  input ready);
  modport sink (input valid, mode, operand_a, operand_b, flags_in, bit_index,
                output ready);
endinterface

interface e8alu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic [3:0] flags_out;
  logic       write_back;

  modport source (output valid, result, flags_out, write_back, input ready);
  modport sink (input valid, result, flags_out, write_back, output ready);
endinterface

/* rtl/e8alu_arith.sv */
`timescale 1ns / 1ps

module e8alu_arith (
  input  logic              clk,
  input  logic              rst_n,
  e8alu_in_if.sink          in_ch,
  output logic              valid_o,
  input  logic              ready_i,
  output e8alu_pkg::s1_t    data_o
);

  logic           valid_r;
  e8alu_pkg::s1_t data_r;
  e8alu_pkg::s1_t data_nxt;
  logic           cin;
  logic [4:0]     h_add_sum;
  logic [4:0]     h_sub_diff;

  assign in_ch.ready = !valid_r || ready_i;
  assign valid_o     = valid_r;
  assign data_o      = data_r;

  always_comb begin
    data_nxt.op  = e8alu_pkg::alu_op_t'(in_ch.mode);
    data_nxt.a   = in_ch.operand_a;
    data_nxt.b   = in_ch.operand_b;
    data_nxt.f   = in_ch.flags_in;
    data_nxt.idx = in_ch.bit_index;
    cin = ((data_nxt.op == e8alu_pkg::OP_ADC) || (data_nxt.op == e8alu_pkg::OP_SBC))
          ? in_ch.flags_in[e8alu_pkg::FLAG_C] : 1'b0;
    data_nxt.sum  = {1'b0, in_ch.operand_a} + {1'b0, in_ch.operand_b} + {8'd0, cin};
    data_nxt.diff = {1'b0, in_ch.operand_a} - {1'b0, in_ch.operand_b} - {8'd0, cin};
    h_add_sum  = {1'b0, in_ch.operand_a[3:0]} + {1'b0, in_ch.operand_b[3:0]} + {4'd0, cin};
    h_sub_diff = {1'b0, in_ch.operand_a[3:0]} - {1'b0, in_ch.operand_b[3:0]} - {4'd0, cin};
    data_nxt.h_add = h_add_sum[4];
    data_nxt.h_sub = h_sub_diff[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ready_i |=> valid_r)
    else $error("stage 1 item dropped during stall");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> valid_r)
    else $error("accepted item missing from stage 1");

endmodule

/* rtl/e8alu_exec.sv */
`timescale 1ns / 1ps

module e8alu_exec (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  e8alu_pkg::s1_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output e8alu_pkg::s2_t data_o
);

  logic           valid_r;
  e8alu_pkg::s2_t data_r;
  e8alu_pkg::s2_t data_nxt;
  logic [7:0]     a;
  logic           cin;
  logic           daa_hi;
  logic           daa_lo;
  logic [7:0]     daa_adj;
  logic           is_sub;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    a   = data_i.a;
    cin = data_i.f[e8alu_pkg::FLAG_C];

    // decimal adjust
    if (data_i.f[e8alu_pkg::FLAG_N]) begin
      daa_hi = cin;
      daa_lo = data_i.f[e8alu_pkg::FLAG_H];
    end else begin
      daa_hi = cin || (a > e8alu_pkg::DAA_HI_LIM);
      daa_lo = data_i.f[e8alu_pkg::FLAG_H] || (a[3:0] > e8alu_pkg::DAA_LO_LIM);
    end
    daa_adj = (daa_hi ? e8alu_pkg::DAA_HI_ADJ : 8'h00) |
              (daa_lo ? e8alu_pkg::DAA_LO_ADJ : 8'h00);

    is_sub = (data_i.op == e8alu_pkg::OP_SUB) || (data_i.op == e8alu_pkg::OP_SBC) ||
             (data_i.op == e8alu_pkg::OP_CP);

    data_nxt.result = a;
    data_nxt.wb     = 1'b1;
    data_nxt.z_use  = 1'b1;
    data_nxt.z_fix  = data_i.f[e8alu_pkg::FLAG_Z];
    data_nxt.nhc    = 3'b000;

    case (data_i.op)
      e8alu_pkg::OP_ADD, e8alu_pkg::OP_ADC: begin
        data_nxt.result = data_i.sum[7:0];
        data_nxt.nhc    = {1'b0, data_i.h_add, data_i.sum[8]};
      end
      e8alu_pkg::OP_SUB, e8alu_pkg::OP_SBC: begin
        data_nxt.result = data_i.diff[7:0];
        data_nxt.nhc    = {1'b1, data_i.h_sub, data_i.diff[8]};
      end
      e8alu_pkg::OP_CP: begin
        data_nxt.wb  = 1'b0;
        data_nxt.nhc = {1'b1, data_i.h_sub, data_i.diff[8]};
      end
      e8alu_pkg::OP_AND: begin
        data_nxt.result = a & data_i.b;
        data_nxt.nhc    = 3'b010;
      end
      e8alu_pkg::OP_XOR: data_nxt.result = a ^ data_i.b;
      e8alu_pkg::OP_OR:  data_nxt.result = a | data_i.b;
      e8alu_pkg::OP_INC: begin
        data_nxt.result = a + 8'd1;
        data_nxt.nhc    = {1'b0, a[3:0] == 4'hF, cin};
      end
      e8alu_pkg::OP_DEC: begin
        data_nxt.result = a - 8'd1;
        data_nxt.nhc    = {1'b1, a[3:0] == 4'h0, cin};
      end
      e8alu_pkg::OP_DAA: begin
        data_nxt.result = data_i.f[e8alu_pkg::FLAG_N] ? (a - daa_adj) : (a + daa_adj);
        data_nxt.nhc    = {data_i.f[e8alu_pkg::FLAG_N], 1'b0,
                           data_i.f[e8alu_pkg::FLAG_N] ? cin : daa_hi};
      end
      e8alu_pkg::OP_CPL: begin
        data_nxt.result = ~a;
        data_nxt.z_use  = 1'b0;
        data_nxt.nhc    = {2'b11, cin};
      end
      e8alu_pkg::OP_SCF: begin
        data_nxt.wb    = 1'b0;
        data_nxt.z_use = 1'b0;
        data_nxt.nhc   = 3'b001;
      end
      e8alu_pkg::OP_CCF: begin
        data_nxt.wb    = 1'b0;
        data_nxt.z_use = 1'b0;
        data_nxt.nhc   = {2'b00, ~cin};
      end
      e8alu_pkg::OP_RLC, e8alu_pkg::OP_RLCA: begin
        data_nxt.result = {a[6:0], a[7]};
        data_nxt.nhc    = {2'b00, a[7]};
      end
      e8alu_pkg::OP_RRC, e8alu_pkg::OP_RRCA: begin
        data_nxt.result = {a[0], a[7:1]};
        data_nxt.nhc    = {2'b00, a[0]};
      end
      e8alu_pkg::OP_RL, e8alu_pkg::OP_RLA: begin
        data_nxt.result = {a[6:0], cin};
        data_nxt.nhc    = {2'b00, a[7]};
      end
      e8alu_pkg::OP_RR, e8alu_pkg::OP_RRA: begin
        data_nxt.result = {cin, a[7:1]};
        data_nxt.nhc    = {2'b00, a[0]};
      end
      e8alu_pkg::OP_SLA: begin
        data_nxt.result = {a[6:0], 1'b0};
        data_nxt.nhc    = {2'b00, a[7]};
      end
      e8alu_pkg::OP_SRA: begin
        data_nxt.result = {a[7], a[7:1]};
        data_nxt.nhc    = {2'b00, a[0]};
      end
      e8alu_pkg::OP_SWAP: data_nxt.result = {a[3:0], a[7:4]};
      e8alu_pkg::OP_SRL: begin
        data_nxt.result = {1'b0, a[7:1]};
        data_nxt.nhc    = {2'b00, a[0]};
      end
      e8alu_pkg::OP_BIT: begin
        data_nxt.wb    = 1'b0;
        data_nxt.z_use = 1'b0;
        data_nxt.z_fix = ~a[data_i.idx];
        data_nxt.nhc   = {2'b01, cin};
      end
      e8alu_pkg::OP_RES: begin
        data_nxt.result = a & ~(8'h01 << data_i.idx);
        data_nxt.z_use  = 1'b0;
        data_nxt.nhc    = data_i.f[2:0];
      end
      e8alu_pkg::OP_SET: begin
        data_nxt.result = a | (8'h01 << data_i.idx);
        data_nxt.z_use  = 1'b0;
        data_nxt.nhc    = data_i.f[2:0];
      end
      default: begin
        data_nxt.wb    = 1'b0;
        data_nxt.z_use = 1'b0;
        data_nxt.nhc   = data_i.f[2:0];
      end
    endcase

    // accumulator rotates always clear z
    if ((data_i.op == e8alu_pkg::OP_RLCA) || (data_i.op == e8alu_pkg::OP_RRCA) ||
        (data_i.op == e8alu_pkg::OP_RLA) || (data_i.op == e8alu_pkg::OP_RRA)) begin
      data_nxt.z_use = 1'b0;
      data_nxt.z_fix = 1'b0;
    end

    data_nxt.z_val = is_sub ? data_i.diff[7:0] : data_nxt.result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  a_cp_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i && ready_o && (data_i.op == e8alu_pkg::OP_CP) |=> valid_r && !data_r.wb)
    else $error("compare item marked for write back");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ready_i |=> valid_r && $stable(data_r))
    else $error("stage 2 item changed during stall");

endmodule

/* rtl/e8alu_flags.sv */
`timescale 1ns / 1ps

module e8alu_flags (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  e8alu_pkg::s2_t data_i,
  e8alu_out_if.source    out_ch
);

  logic       valid_r;
  logic [7:0] result_r;
  logic [3:0] flags_r;
  logic       wb_r;
  logic [3:0] flags_nxt;

  assign ready_o           = !valid_r || out_ch.ready;
  assign out_ch.valid      = valid_r;
  assign out_ch.result     = result_r;
  assign out_ch.flags_out  = flags_r;
  assign out_ch.write_back = wb_r;

  always_comb begin
    flags_nxt = {data_i.z_use ? (data_i.z_val == 8'h00) : data_i.z_fix, data_i.nhc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      result_r <= data_i.result;
      flags_r  <= flags_nxt;
      wb_r     <= data_i.wb;
    end
  end

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i && ready_o && data_i.z_use |=>
      flags_r[e8alu_pkg::FLAG_Z] == ($past(data_i.z_val) == 8'h00))
    else $error("zero flag does not match tested value");

endmodule

/* rtl/eight_bit_alu_with_flags.sv */
// an accepted item passes through the adder, result select and flags registers in order before it leaves
// throughput: one item per cycle while the output is not stalled, three register stages (adders, result select, flags)
// a stalled output backs up stage by stage; ready falls only when all stages hold items
// reset: synchronous active-low rst_n clears the stage valid bits, pipeline empties
// no state beyond the pipeline; results depend only on each item
`timescale 1ns / 1ps

module eight_bit_alu_with_flags (
  input  logic         clk,
  input  logic         rst_n,
  e8alu_in_if.sink     in_ch,
  e8alu_out_if.source  out_ch
);

  logic           s1_valid;
  logic           s1_ready;
  e8alu_pkg::s1_t s1_data;
  logic           s2_valid;
  logic           s2_ready;
  e8alu_pkg::s2_t s2_data;

  e8alu_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  e8alu_exec u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  e8alu_flags u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .out_ch  (out_ch)
  );

endmodule
